// ----- hw/rtl/nsr_pkg.sv -----
// Shared types and constants for the Newton-Raphson square root core.
// Used by the controller, the datapath, the divider and the top level.
package nsr_pkg;

    // Operand and result formats
    localparam int NSR_WIDTH     = 32;
    localparam int NSR_FRAC_BITS = 16;
    localparam int NSR_N_BITS    = NSR_WIDTH + NSR_FRAC_BITS;
    localparam int NSR_ROOT_BITS = 24;
    localparam int NSR_CNT_BITS  = $clog2(NSR_N_BITS);

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV_WAIT,
        ST_CHECK,
        ST_OUTPUT
    } nsr_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture operand, x = N
        logic div_start;  // start N / x
        logic step;       // x = (x + N/x) / 2
        logic finish;     // latch x as the result
    } nsr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic n_zero;     // operand is zero
        logic div_done;   // quotient is ready
        logic converged;  // new estimate >= current estimate
    } nsr_status_t;

endpackage

// ----- hw/rtl/newton_square_root_core.sv -----
// Newton-Raphson square root of an unsigned Q16.16 operand, result in unsigned Q8.16.
// Each division runs in order: issue in the test state, the divider's shift-subtract
// steps, its registered done flag, then the stop test; a zero operand skips division.
// One item at a time: a new operand is taken only in the idle state, after the result
// has been passed to the output register.
// Async active-low rst_n clears control state. Uses nsr_pkg and the submodules.
module newton_square_root_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               value_valid,
    output logic                               value_ready,
    input  logic [nsr_pkg::NSR_WIDTH-1:0]      value,
    output logic                               root_valid,
    input  logic                               root_ready,
    output logic [nsr_pkg::NSR_ROOT_BITS-1:0]  root
);
    import nsr_pkg::*;

    nsr_cmd_t    cmd;
    nsr_status_t status;

    // Sequencing
    nsr_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .root_valid  (root_valid),
        .root_ready  (root_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // Arithmetic
    nsr_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .value  (value),
        .root   (root)
    );

endmodule

// ----- hw/rtl/nsr_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nsr_pkg for the operand width and counter width.
module nsr_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [nsr_pkg::NSR_N_BITS-1:0]  dividend,
    input  logic [nsr_pkg::NSR_N_BITS-1:0]  divisor,
    output logic [nsr_pkg::NSR_N_BITS-1:0]  quotient,
    output logic                            done
);
    import nsr_pkg::*;

    localparam logic [NSR_CNT_BITS-1:0] LAST_CNT = NSR_CNT_BITS'(NSR_N_BITS - 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [NSR_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [NSR_N_BITS:0]     rem_reg, rem_next;
    logic [NSR_N_BITS-1:0]   quo_reg, quo_next;
    logic [NSR_N_BITS-1:0]   dsr_reg, dsr_next;

    logic [NSR_N_BITS:0]     rem_shift;
    logic [NSR_N_BITS:0]     diff;

    // One shift-subtract step
    always_comb
    begin
        rem_shift = {rem_reg[NSR_N_BITS-1:0], quo_reg[NSR_N_BITS-1]};
        diff      = rem_shift - {1'b0, dsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (diff[NSR_N_BITS])
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[NSR_N_BITS-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff;
                quo_next = {quo_reg[NSR_N_BITS-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_CNT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- hw/rtl/nsr_datapath.sv -----
// Datapath: operand N, estimate x, shared divider, update and stop test.
// Depends on nsr_pkg and nsr_divider.
module nsr_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  nsr_pkg::nsr_cmd_t                  cmd,
    output nsr_pkg::nsr_status_t               status,
    input  logic [nsr_pkg::NSR_WIDTH-1:0]      value,
    output logic [nsr_pkg::NSR_ROOT_BITS-1:0]  root
);
    import nsr_pkg::*;

    logic [NSR_N_BITS-1:0]    n_reg, n_next;
    logic [NSR_N_BITS-1:0]    x_reg, x_next;
    logic [NSR_ROOT_BITS-1:0] root_reg, root_next;

    logic [NSR_N_BITS-1:0]    quotient;
    logic                     div_done;
    logic [NSR_N_BITS:0]      sum;
    logic [NSR_N_BITS-1:0]    y;

    // Shared iterative divider computes N / x
    nsr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (n_reg),
        .divisor  (x_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // New estimate: halved sum of x and the quotient
    assign sum = {1'b0, x_reg} + {1'b0, quotient};
    assign y   = sum[NSR_N_BITS:1];

    always_comb
    begin
        n_next    = n_reg;
        x_next    = x_reg;
        root_next = root_reg;
        if (cmd.load)
        begin
            n_next = {value, {NSR_FRAC_BITS{1'b0}}};
            x_next = {value, {NSR_FRAC_BITS{1'b0}}};
        end
        else if (cmd.step)
        begin
            x_next = y;
        end
        if (cmd.finish)
        begin
            root_next = x_reg[NSR_ROOT_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        x_reg    <= x_next;
        root_reg <= root_next;
    end

    assign status.n_zero    = (n_reg == '0);
    assign status.div_done  = div_done;
    assign status.converged = (y >= x_reg);
    assign root             = root_reg;

endmodule

// ----- hw/rtl/nsr_controller.sv -----
// Controller state machine: sequences load, divisions, updates and output.
// Depends on nsr_pkg for the state, command and status types.
module nsr_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  value_valid,
    output logic                  value_ready,
    output logic                  root_valid,
    input  logic                  root_ready,
    input  nsr_pkg::nsr_status_t  status,
    output nsr_pkg::nsr_cmd_t     cmd
);
    import nsr_pkg::*;

    nsr_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        value_ready = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                value_ready = 1'b1;
                if (value_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (status.n_zero)
                begin
                    state_next = ST_OUTPUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.converged)
                begin
                    state_next = ST_OUTPUT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_OUTPUT:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || root_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !root_ready) || cmd.finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign root_valid = out_valid_reg;

endmodule
